/* design/sawbc_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the set-associative write-back cache tag controller
package sawbc_pkg;

    localparam int ADDR_W     = 32;
    localparam int LAT_W      = 8;
    localparam int STALL_W    = 9;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_ENABLE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKUP_LATENCY = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LATENCY   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LATENCY  = 8'd3;

    localparam logic             RST_CACHE_ENABLE   = 1'b1;
    localparam logic [LAT_W-1:0] RST_LOOKUP_LATENCY = 8'd0;
    localparam logic [LAT_W-1:0] RST_READ_LATENCY   = 8'd30;
    localparam logic [LAT_W-1:0] RST_WRITE_LATENCY  = 8'd10;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_STORE = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        logic [STALL_W-1:0] stall_cycles;
        logic               hit;
        logic               did_writeback;
        logic [CNT_W-1:0]   load_count;
        logic [CNT_W-1:0]   store_count;
        logic [CNT_W-1:0]   load_miss_count;
        logic [CNT_W-1:0]   store_miss_count;
        logic [CNT_W-1:0]   writeback_count;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic store;
        logic load_miss;
        logic store_miss;
        logic writeback;
    } t_evt;

endpackage

/* design/sawbc_tag_store.sv */
`timescale 1ns / 1ps
// per-set tag, valid, dirty and victim pointer memory with clearing pass and write bypass
module sawbc_tag_store
    import sawbc_pkg::*;
#(
    parameter int NUM_SETS = 8,
    parameter int ROW_W    = 105
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [$clog2(NUM_SETS)-1:0] i_rd_set,
    output logic [ROW_W-1:0]            o_rd_row,
    input  logic                        i_wr_en,
    input  logic [$clog2(NUM_SETS)-1:0] i_wr_set,
    input  logic [ROW_W-1:0]            i_wr_row,
    output logic                        o_clearing
);

    localparam int SET_W = $clog2(NUM_SETS);

    logic [ROW_W-1:0] r_mem [NUM_SETS];
    logic [ROW_W-1:0] r_rd_row;
    logic             r_clr_active;
    logic [SET_W-1:0] r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_idx    <= '0;
        end else if (r_clr_active) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == SET_W'(NUM_SETS - 1)) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_set] <= i_wr_row;
        end
    end

    // same-set write in this cycle wins over the stored row
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_set == i_rd_set)) begin
                r_rd_row <= i_wr_row;
            end else begin
                r_rd_row <= r_mem[i_rd_set];
            end
        end
    end

    assign o_rd_row   = r_rd_row;
    assign o_clearing = r_clr_active;

endmodule

/* design/sawbc_lookup.sv */
`timescale 1ns / 1ps
// tag compare, victim choice, row update and stall calculation for one access
module sawbc_lookup
    import sawbc_pkg::*;
#(
    parameter int NUM_WAYS = 4,
    parameter int TAG_W    = 24
) (
    input  logic                     i_valid,
    input  logic                     i_enable,
    input  logic                     i_req_type,
    input  logic [TAG_W-1:0]         i_tag,
    input  logic [NUM_WAYS*(TAG_W+2)+$clog2(NUM_WAYS)-1:0] i_row,
    input  logic [LAT_W-1:0]         i_lookup_lat,
    input  logic [LAT_W-1:0]         i_read_lat,
    input  logic [LAT_W-1:0]         i_write_lat,
    output logic [STALL_W-1:0]       o_stall,
    output logic                     o_hit,
    output logic                     o_wb,
    output t_evt                     o_evt,
    output logic                     o_wr_en,
    output logic [NUM_WAYS*(TAG_W+2)+$clog2(NUM_WAYS)-1:0] o_row
);

    localparam int PTR_W = $clog2(NUM_WAYS);
    localparam int ENT_W = TAG_W + 2;
    localparam int ROW_W = NUM_WAYS * ENT_W + PTR_W;

    logic [TAG_W-1:0]    way_tag [NUM_WAYS];
    logic [NUM_WAYS-1:0] way_valid;
    logic [NUM_WAYS-1:0] way_dirty;
    logic                hit_any;
    logic [PTR_W-1:0]    hit_way;
    logic [PTR_W-1:0]    victim;
    logic [PTR_W-1:0]    next_ptr;
    logic                victim_dirty;
    logic                is_store;
    logic                act;

    assign is_store = (i_req_type == REQ_STORE);
    assign act      = i_valid && i_enable;

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            way_tag[w]   = i_row[w*ENT_W +: TAG_W];
            way_valid[w] = i_row[w*ENT_W + TAG_W];
            way_dirty[w] = i_row[w*ENT_W + TAG_W + 1];
        end
    end

    // lowest matching way wins
    always_comb begin
        hit_any = 1'b0;
        hit_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (way_valid[w] && (way_tag[w] == i_tag)) begin
                hit_any = 1'b1;
                hit_way = PTR_W'(w);
            end
        end
    end

    assign victim       = i_row[ROW_W-1 -: PTR_W];
    assign victim_dirty = way_dirty[victim];
    assign next_ptr     = (victim == PTR_W'(NUM_WAYS - 1)) ? '0 : victim + 1'b1;

    always_comb begin
        o_row = i_row;
        if (hit_any) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                if ((PTR_W'(w) == hit_way) && is_store) begin
                    o_row[w*ENT_W + TAG_W + 1] = 1'b1;
                end
            end
        end else begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (PTR_W'(w) == victim) begin
                    o_row[w*ENT_W +: ENT_W] = {is_store, 1'b1, i_tag};
                end
            end
            o_row[ROW_W-1 -: PTR_W] = next_ptr;
        end
    end

    always_comb begin
        if (!i_enable) begin
            o_stall = is_store ? {1'b0, i_write_lat} : {1'b0, i_read_lat};
        end else if (hit_any) begin
            o_stall = {1'b0, i_lookup_lat};
        end else begin
            o_stall = {1'b0, i_read_lat}
                    + (victim_dirty ? {1'b0, i_write_lat} : STALL_W'(0));
        end
    end

    assign o_hit   = i_enable && hit_any;
    assign o_wb    = i_enable && !hit_any && victim_dirty;
    assign o_wr_en = act;

    assign o_evt.load       = act && !is_store;
    assign o_evt.store      = act && is_store;
    assign o_evt.load_miss  = act && !is_store && !hit_any;
    assign o_evt.store_miss = act && is_store && !hit_any;
    assign o_evt.writeback  = act && !hit_any && victim_dirty;

endmodule

/* design/sawbc_counters.sv */
`timescale 1ns / 1ps
// five wrapping event counters
module sawbc_counters
    import sawbc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_evt             i_evt,
    output logic [CNT_W-1:0] o_load_count,
    output logic [CNT_W-1:0] o_store_count,
    output logic [CNT_W-1:0] o_load_miss_count,
    output logic [CNT_W-1:0] o_store_miss_count,
    output logic [CNT_W-1:0] o_writeback_count
);

    logic [CNT_W-1:0] r_load;
    logic [CNT_W-1:0] r_store;
    logic [CNT_W-1:0] r_load_miss;
    logic [CNT_W-1:0] r_store_miss;
    logic [CNT_W-1:0] r_wb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load       <= '0;
            r_store      <= '0;
            r_load_miss  <= '0;
            r_store_miss <= '0;
            r_wb         <= '0;
        end else begin
            r_load       <= r_load + CNT_W'(i_evt.load);
            r_store      <= r_store + CNT_W'(i_evt.store);
            r_load_miss  <= r_load_miss + CNT_W'(i_evt.load_miss);
            r_store_miss <= r_store_miss + CNT_W'(i_evt.store_miss);
            r_wb         <= r_wb + CNT_W'(i_evt.writeback);
        end
    end

    assign o_load_count       = r_load;
    assign o_store_count      = r_store;
    assign o_load_miss_count  = r_load_miss;
    assign o_store_miss_count = r_store_miss;
    assign o_writeback_count  = r_wb;

endmodule

/* design/set_assoc_writeback_cache_tags.sv */
`timescale 1ns / 1ps
// top level of the set-associative write-back cache tag controller
//
// An access transfer (load or store with byte address on i_req) is taken at a
// rising edge with start high and busy low. A new access can be taken every
// cycle, one access per cycle sustained. The access is registered together
// with the tag row of its set; the compare, victim choice and row update are
// done in the next cycle, and the result is registered onto o_rsp with
// o_rsp_valid high for exactly one cycle. The event counts on o_rsp are those
// after the access. Back-to-back accesses to one set see each other's updates
// through a bypass on the row memory.
// Configuration writes use i_cfg_valid / o_cfg_ready (always ready) with a
// register index and 8-bit data; indexes past the last register are ignored.
// After reset the row memory is cleared one set per cycle, with busy high;
// configuration writes are taken during that time. The receiver cannot
// stall: each result is present for one cycle only.
module set_assoc_writeback_cache_tags
    import sawbc_pkg::*;
#(
    parameter int NUM_SETS   = 8,
    parameter int NUM_WAYS   = 4,
    parameter int LINE_BYTES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_req                  i_req,
    output logic                  o_rsp_valid,
    output t_rsp                  o_rsp,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int OFS_W = $clog2(LINE_BYTES);
    localparam int SET_W = $clog2(NUM_SETS);
    localparam int TAG_W = ADDR_W - OFS_W - SET_W;
    localparam int PTR_W = $clog2(NUM_WAYS);
    localparam int ROW_W = NUM_WAYS * (TAG_W + 2) + PTR_W;

    logic             r_cache_enable;
    logic [LAT_W-1:0] r_lookup_lat;
    logic [LAT_W-1:0] r_read_lat;
    logic [LAT_W-1:0] r_write_lat;

    logic             accept;
    logic             clearing;
    logic             r_stage_valid;
    t_req             r_stage_req;
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] wr_row;
    logic             wr_en;

    logic [STALL_W-1:0] n_stall;
    logic               n_hit;
    logic               n_wb;
    t_evt               evt;

    logic               r_rsp_valid;
    logic [STALL_W-1:0] r_stall;
    logic               r_hit;
    logic               r_wb;

    logic [CNT_W-1:0] load_count;
    logic [CNT_W-1:0] store_count;
    logic [CNT_W-1:0] load_miss_count;
    logic [CNT_W-1:0] store_miss_count;
    logic [CNT_W-1:0] writeback_count;

    assign busy        = clearing;
    assign accept      = start && !clearing;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_enable <= RST_CACHE_ENABLE;
            r_lookup_lat   <= RST_LOOKUP_LATENCY;
            r_read_lat     <= RST_READ_LATENCY;
            r_write_lat    <= RST_WRITE_LATENCY;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CACHE_ENABLE:   r_cache_enable <= i_cfg_data[0];
                CFG_LOOKUP_LATENCY: r_lookup_lat   <= i_cfg_data[LAT_W-1:0];
                CFG_READ_LATENCY:   r_read_lat     <= i_cfg_data[LAT_W-1:0];
                CFG_WRITE_LATENCY:  r_write_lat    <= i_cfg_data[LAT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
        end else begin
            r_stage_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stage_req <= i_req;
        end
    end

    sawbc_tag_store #(
        .NUM_SETS (NUM_SETS),
        .ROW_W    (ROW_W)
    ) u_tag_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_set   (i_req.address[OFS_W +: SET_W]),
        .o_rd_row   (rd_row),
        .i_wr_en    (wr_en),
        .i_wr_set   (r_stage_req.address[OFS_W +: SET_W]),
        .i_wr_row   (wr_row),
        .o_clearing (clearing)
    );

    sawbc_lookup #(
        .NUM_WAYS (NUM_WAYS),
        .TAG_W    (TAG_W)
    ) u_lookup (
        .i_valid      (r_stage_valid),
        .i_enable     (r_cache_enable),
        .i_req_type   (r_stage_req.req_type),
        .i_tag        (r_stage_req.address[ADDR_W-1 -: TAG_W]),
        .i_row        (rd_row),
        .i_lookup_lat (r_lookup_lat),
        .i_read_lat   (r_read_lat),
        .i_write_lat  (r_write_lat),
        .o_stall      (n_stall),
        .o_hit        (n_hit),
        .o_wb         (n_wb),
        .o_evt        (evt),
        .o_wr_en      (wr_en),
        .o_row        (wr_row)
    );

    sawbc_counters u_counters (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_evt              (evt),
        .o_load_count       (load_count),
        .o_store_count      (store_count),
        .o_load_miss_count  (load_miss_count),
        .o_store_miss_count (store_miss_count),
        .o_writeback_count  (writeback_count)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= r_stage_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_stage_valid) begin
            r_stall <= n_stall;
            r_hit   <= n_hit;
            r_wb    <= n_wb;
        end
    end

    // counters are updated at the same edge as the result register
    always_comb begin
        o_rsp.stall_cycles     = r_stall;
        o_rsp.hit              = r_hit;
        o_rsp.did_writeback    = r_wb;
        o_rsp.load_count       = load_count;
        o_rsp.store_count      = store_count;
        o_rsp.load_miss_count  = load_miss_count;
        o_rsp.store_miss_count = store_miss_count;
        o_rsp.writeback_count  = writeback_count;
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// self-checking testbench of the set-associative write-back cache tag controller
module tb_top;
    import sawbc_pkg::*;

    localparam int NUM_SETS   = 8;
    localparam int NUM_WAYS   = 4;
    localparam int LINE_BYTES = 32;
    localparam int OFF_W      = $clog2(LINE_BYTES);
    localparam int SET_W      = $clog2(NUM_SETS);
    localparam int WAY_W      = $clog2(NUM_WAYS);
    localparam int TAG_W      = ADDR_W - OFF_W - SET_W;
    localparam int NUM_LINES  = NUM_SETS * NUM_WAYS;
    localparam int POOL_N     = 6;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_req                  i_req       = '0;
    logic                  o_rsp_valid;
    t_rsp                  o_rsp;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    set_assoc_writeback_cache_tags #(
        .NUM_SETS   (NUM_SETS),
        .NUM_WAYS   (NUM_WAYS),
        .LINE_BYTES (LINE_BYTES)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // register mirror
    logic             cfg_enable = RST_CACHE_ENABLE;
    logic [LAT_W-1:0] cfg_lookup = RST_LOOKUP_LATENCY;
    logic [LAT_W-1:0] cfg_read   = RST_READ_LATENCY;
    logic [LAT_W-1:0] cfg_write  = RST_WRITE_LATENCY;

    // tag store mirror
    logic [TAG_W-1:0] tag_ram    [NUM_LINES] = '{default: '0};
    logic             valid_bits [NUM_LINES] = '{default: 1'b0};
    logic             dirty_bits [NUM_LINES] = '{default: 1'b0};
    logic [WAY_W-1:0] rr_ptr     [NUM_SETS]  = '{default: '0};
    logic [CNT_W-1:0] loads         = '0;
    logic [CNT_W-1:0] stores        = '0;
    logic [CNT_W-1:0] missed_loads  = '0;
    logic [CNT_W-1:0] missed_stores = '0;
    logic [CNT_W-1:0] writebacks    = '0;

    t_req             access_q[$];
    t_rsp             rsp_expected[$];
    logic [TAG_W-1:0] tag_pool [POOL_N];
    bit               no_gaps = 1'b0;
    int               errors  = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_rsp predict_access(input t_req rq);
        t_rsp             r;
        logic             is_store;
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
        int               base;
        int               hit_way;
        int               vic;
        r        = '0;
        is_store = (rq.req_type == REQ_STORE);
        set_idx  = rq.address[OFF_W +: SET_W];
        tag      = rq.address[ADDR_W-1 -: TAG_W];
        base     = set_idx * NUM_WAYS;
        if (!cfg_enable) begin
            r.stall_cycles = is_store ? STALL_W'(cfg_write) : STALL_W'(cfg_read);
        end else begin
            if (is_store) stores++;
            else loads++;
            hit_way = -1;
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (hit_way < 0 && valid_bits[base + w] && tag_ram[base + w] == tag) begin
                    hit_way = w;
                end
            end
            if (hit_way >= 0) begin
                if (is_store) dirty_bits[base + hit_way] = 1'b1;
                r.hit          = 1'b1;
                r.stall_cycles = STALL_W'(cfg_lookup);
            end else begin
                if (is_store) missed_stores++;
                else missed_loads++;
                vic            = base + rr_ptr[set_idx];
                r.stall_cycles = STALL_W'(cfg_read);
                if (dirty_bits[vic]) begin
                    r.stall_cycles  = r.stall_cycles + STALL_W'(cfg_write);
                    r.did_writeback = 1'b1;
                    writebacks++;
                end
                tag_ram[vic]    = tag;
                valid_bits[vic] = 1'b1;
                dirty_bits[vic] = is_store;
                rr_ptr[set_idx] = rr_ptr[set_idx] + 1'b1;
            end
        end
        r.load_count       = loads;
        r.store_count      = stores;
        r.load_miss_count  = missed_loads;
        r.store_miss_count = missed_stores;
        r.writeback_count  = writebacks;
        return r;
    endfunction

    // access driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                rsp_expected.push_back(predict_access(i_req));
            end
            if (!start || !busy) begin
                if (access_q.size() != 0 && (no_gaps || $urandom_range(99) >= 30)) begin
                    start <= 1'b1;
                    i_req <= access_q.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // result monitor
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_rsp_valid) begin
            if (rsp_expected.size() == 0) begin
                report($sformatf("result with nothing expected: %h", o_rsp));
            end else begin
                want = rsp_expected.pop_front();
                check_field("stall_cycles", 32'(o_rsp.stall_cycles), 32'(want.stall_cycles));
                check_field("hit", 32'(o_rsp.hit), 32'(want.hit));
                check_field("did_writeback", 32'(o_rsp.did_writeback),
                            32'(want.did_writeback));
                check_field("load_count", o_rsp.load_count, want.load_count);
                check_field("store_count", o_rsp.store_count, want.store_count);
                check_field("load_miss_count", o_rsp.load_miss_count, want.load_miss_count);
                check_field("store_miss_count", o_rsp.store_miss_count,
                            want.store_miss_count);
                check_field("writeback_count", o_rsp.writeback_count, want.writeback_count);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_CACHE_ENABLE:   cfg_enable = val[0];
            CFG_LOOKUP_LATENCY: cfg_lookup = val;
            CFG_READ_LATENCY:   cfg_read   = val;
            CFG_WRITE_LATENCY:  cfg_write  = val;
            default: ;
        endcase
    endtask

    task automatic load_config(input logic en, input logic [LAT_W-1:0] lk,
                               input logic [LAT_W-1:0] rd, input logic [LAT_W-1:0] wr);
        write_reg(CFG_CACHE_ENABLE, {7'($urandom), en});
        write_reg(CFG_LOOKUP_LATENCY, lk);
        write_reg(CFG_READ_LATENCY, rd);
        write_reg(CFG_WRITE_LATENCY, wr);
        if ($urandom_range(1)) begin
            write_reg(CFG_WRITE_LATENCY + 8'(1 + $urandom_range(251)), 8'($urandom));
        end
    endtask

    task automatic push_access(input logic kind, input logic [ADDR_W-1:0] addr);
        t_req rq;
        rq.req_type = kind;
        rq.address  = addr;
        access_q.push_back(rq);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (access_q.size() != 0 || start || rsp_expected.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [LAT_W-1:0] pick_latency();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return LAT_W'($urandom);
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        if ($urandom_range(99) < 15) return ADDR_W'($urandom);
        return {tag_pool[$urandom_range(POOL_N - 1)], SET_W'($urandom), OFF_W'($urandom)};
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: invalid zero tag, store hit, fill and dirty eviction in set 0
        push_access(REQ_LOAD, 32'h0000_0000);
        push_access(REQ_STORE, 32'h0000_001F);
        push_access(REQ_STORE, 32'hFFFF_FFFF);
        push_access(REQ_LOAD, 32'hFFFF_FFE0);
        for (int t = 1; t <= 4; t++) push_access(REQ_LOAD, ADDR_W'(t) << 8);
        push_access(REQ_LOAD, 32'h0000_0000);
        wait_idle();

        // bypass with masked enable data and ignored indexes
        write_reg(CFG_CACHE_ENABLE, 8'hFE);
        write_reg(CFG_WRITE_LATENCY + 8'd1, 8'h5A);
        write_reg('1, 8'hA5);
        push_access(REQ_LOAD, 32'hFFFF_FFFF);
        push_access(REQ_STORE, 32'h1234_5678);
        wait_idle();

        // line state kept across bypass, widest stall
        load_config(1'b1, 8'hFF, 8'hFF, 8'hFF);
        push_access(REQ_LOAD, 32'hFFFF_FFFF);
        push_access(REQ_STORE, 32'h0000_0400);
        push_access(REQ_STORE, 32'h0000_0500);
        push_access(REQ_STORE, 32'h0000_0600);
        push_access(REQ_STORE, 32'h0000_0700);
        wait_idle();

        load_config(1'b1, 8'h00, 8'h00, 8'h00);
        push_access(REQ_LOAD, 32'h0000_0500);
        push_access(REQ_STORE, 32'h0000_0800);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            no_gaps = (ph == 2);
            load_config($urandom_range(4) != 0, pick_latency(), pick_latency(),
                        pick_latency());
            for (int k = 0; k < POOL_N; k++) tag_pool[k] = TAG_W'($urandom);
            for (int k = 0; k < 72; k++) push_access(1'($urandom_range(1)), pick_address());
            wait_idle();
        end

        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
